// ----- rtl/shtl_pkg.sv -----
// shared types and constants for the symbol hash table lookup/insert core
// no dependencies; imported by every module in rtl/
package shtl_pkg;

  localparam int NAME_W          = 64;
  localparam int BYTE_W          = 8;
  localparam int NAME_BYTES      = 8;
  localparam int HASH_W          = 16;
  localparam int SLOT_OUT_W      = 10;
  localparam int OUT_DATA_W      = 16;
  localparam int DEF_TABLE_SLOTS = 1024;

  // table word: valid flag above the stored name
  localparam int ENTRY_W = NAME_W + 1;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] quotient;
    logic [HASH_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ----- rtl/shtl_divider.sv -----
// constant divider by reciprocal multiplication: quotient registered first, remainder next
// depends on shtl_pkg (div_req_t, div_rsp_t, HASH_W)
module shtl_divider #(
  parameter int DIVISOR = shtl_pkg::DEF_TABLE_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  shtl_pkg::div_req_t req,
  output shtl_pkg::div_rsp_t rsp
);
  import shtl_pkg::*;

  // quotient = (dividend * RECIP) >> SHIFT, exact for every HASH_W-bit dividend
  localparam int     DIV_LOG = $clog2(DIVISOR);
  localparam int     SHIFT   = HASH_W + DIV_LOG;
  localparam int     RECIP_W = HASH_W + 1;
  localparam int     PROD_W  = HASH_W + RECIP_W;
  localparam longint RECIP_L = ((longint'(1) << SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam logic [HASH_W-1:0]  DIV_C = HASH_W'(DIVISOR);

  logic              phase2;     // quotient registered, remainder due next edge
  logic              done;
  logic [HASH_W-1:0] dividend;
  logic [HASH_W-1:0] quot;
  logic [HASH_W-1:0] rem;
  logic [PROD_W-1:0] prod;
  logic [HASH_W-1:0] quot_next;
  logic [HASH_W-1:0] back;       // quotient times divisor, never above the dividend

  assign prod      = PROD_W'(req.dividend) * PROD_W'(RECIP);
  assign quot_next = HASH_W'(prod >> SHIFT);
  assign back      = quot * DIV_C;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      done   <= phase2;
      phase2 <= req.start;
      if (req.start) begin
        dividend <= req.dividend;
        quot     <= quot_next;
      end
      if (phase2) begin
        rem <= dividend - back;
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quot;
  assign rsp.remainder = rem;

endmodule

// ----- rtl/shtl_table_mem.sv -----
// name table storage: one write port, one registered read port
// depends on shtl_pkg (ENTRY_W)
module shtl_table_mem #(
  parameter int SLOTS = shtl_pkg::DEF_TABLE_SLOTS,
  parameter int AW    = $clog2(shtl_pkg::DEF_TABLE_SLOTS)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [shtl_pkg::ENTRY_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [shtl_pkg::ENTRY_W-1:0] rd_data
);
  import shtl_pkg::*;

  logic [ENTRY_W-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/symbol_hash_table_lookup_insert_core.sv -----
// top level: symbol hash table lookup with insert on miss (double hashing)
// depends on shtl_pkg, shtl_divider, shtl_table_mem
//
//  channel  | dir | beat fields (low bit up)
//  ---------+-----+----------------------------------------------------------
//  s_axis   | in  | tdata[63:0] symbol_name
//  m_axis   | out | tdata[9:0] slot_index, [10] was_found, [11] table_overflow,
//           |     | [15:12] zero
//
// sequence: an item is accepted, hashed byte by byte up to the first zero byte,
//   passed through the divider for its start and then its step, and probed one
//   slot after another until a hit, an empty slot or overflow; the shared divider
//   and the single table read port serve one item at a time
// reset: rst clears the state, sweep address, wrap flag and output valid, then a
//   sweep writes every table slot empty, with s_axis_tready low throughout
// stalls: a result waits in the m_axis register while the next beat is taken;
//   an item that finishes while that register is still full holds in place
module symbol_hash_table_lookup_insert_core #(
  parameter int TABLE_SLOTS = shtl_pkg::DEF_TABLE_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [shtl_pkg::NAME_W-1:0]     s_axis_tdata,  // symbol_name
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [shtl_pkg::OUT_DATA_W-1:0] m_axis_tdata   // slot_index, was_found,
                                                        // table_overflow, pad
);
  import shtl_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int PW     = SLOT_W + 1;            // signed probe position
  localparam int BCNT_W = $clog2(NAME_BYTES);
  localparam logic signed [PW-1:0] SLOTS_M1 = PW'(TABLE_SLOTS - 1);
  localparam logic [SLOT_W-1:0]    LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_DIV1_GO,
    ST_DIV1_WAIT,
    ST_DIV2_GO,
    ST_DIV2_WAIT,
    ST_PROBE,
    ST_CHECK
  } state_t;

  state_t state;

  logic [NAME_W-1:0]      name;       // full name for the compare and insert
  logic [NAME_W-1:0]      name_sh;    // bytes still to hash, next one lowest
  logic [BCNT_W-1:0]      byte_cnt;
  logic [HASH_W-1:0]      hash;
  logic [SLOT_W-1:0]      step;
  logic signed [PW-1:0]   pos;
  logic                   wrapped;
  logic [SLOT_W-1:0]      clr_addr;

  logic [SLOT_OUT_W-1:0]  out_slot;
  logic                   out_found;
  logic                   out_ovf;

  div_req_t               div_req;
  div_rsp_t               div_rsp;

  logic                   mem_wr_en;
  logic [SLOT_W-1:0]      mem_wr_addr;
  logic [ENTRY_W-1:0]     mem_wr_data;
  logic                   mem_rd_en;
  logic [SLOT_W-1:0]      mem_rd_addr;
  logic [ENTRY_W-1:0]     mem_rd_data;

  logic [BYTE_W-1:0]      cur_byte;
  logic [HASH_W-1:0]      hash_sum;
  logic                   pos_le0;
  logic signed [PW-1:0]   pos_probe;  // next probe position: wrapped and decremented, or decremented
  logic                   out_free;
  logic                   entry_valid;
  logic                   entry_match;
  logic                   insert_now;
  logic                   res_load;

  // ---------------------------------------------------------------------------
  // hash datapath: add one byte, keep 16 bits, swap the two hash bytes
  assign cur_byte = name_sh[BYTE_W-1:0];
  assign hash_sum = hash + HASH_W'(cur_byte);

  // ---------------------------------------------------------------------------
  // probe arithmetic: either wrap-and-decrement or plain decrement
  assign pos_le0   = pos[PW-1] || (pos == '0);
  assign pos_probe = pos_le0 ? (pos + SLOTS_M1) : (pos - PW'(1));

  // result register is free when empty or being drained this cycle
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign entry_valid = mem_rd_data[ENTRY_W-1];
  assign entry_match = (mem_rd_data[NAME_W-1:0] == name);
  assign insert_now  = (state == ST_CHECK) && !entry_valid && out_free;

  // a result enters the output register: overflow on a probe, hit or empty slot on a check
  assign res_load = out_free &&
                    (((state == ST_PROBE) && pos_le0 && wrapped) ||
                     ((state == ST_CHECK) && (!entry_valid || entry_match)));

  // ---------------------------------------------------------------------------
  // shared divider: first pass hash / slots, second pass quotient mod slots
  always_comb begin
    div_req.start    = (state == ST_DIV1_GO) || (state == ST_DIV2_GO);
    div_req.dividend = (state == ST_DIV2_GO) ? div_rsp.quotient : hash;
  end

  shtl_divider #(
    .DIVISOR (TABLE_SLOTS)
  ) u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // table port control: clearing sweep or insert on the write side
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = pos[SLOT_W-1:0];
    mem_wr_data = {1'b1, name};
    if (state == ST_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_addr;
      mem_wr_data = '0;
    end else if (insert_now) begin
      mem_wr_en = 1'b1;
    end
  end

  // read only on a real probe, so the read register holds during a stall
  assign mem_rd_en   = (state == ST_PROBE) && !(pos_le0 && wrapped);
  assign mem_rd_addr = pos_probe[SLOT_W-1:0];

  shtl_table_mem #(
    .SLOTS (TABLE_SLOTS),
    .AW    (SLOT_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // ---------------------------------------------------------------------------
  // sequencer with the registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      wrapped       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (res_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_SLOT) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (s_axis_tvalid) begin
            name     <= s_axis_tdata;
            name_sh  <= s_axis_tdata;
            hash     <= '0;
            byte_cnt <= '0;
            state    <= ST_HASH;
          end
        end

        ST_HASH: begin
          // a zero byte ends the hashed part of the name
          if (cur_byte == '0) begin
            state <= ST_DIV1_GO;
          end else begin
            hash     <= {hash_sum[BYTE_W-1:0], hash_sum[HASH_W-1:BYTE_W]};
            name_sh  <= name_sh >> BYTE_W;
            byte_cnt <= byte_cnt + 1'b1;
            if (byte_cnt == BCNT_W'(NAME_BYTES - 1)) begin
              state <= ST_DIV1_GO;
            end
          end
        end

        ST_DIV1_GO: begin
          state <= ST_DIV1_WAIT;
        end

        ST_DIV1_WAIT: begin
          if (div_rsp.done) begin
            pos   <= PW'(div_rsp.remainder[SLOT_W-1:0]);
            state <= ST_DIV2_GO;
          end
        end

        ST_DIV2_GO: begin
          state <= ST_DIV2_WAIT;
        end

        ST_DIV2_WAIT: begin
          if (div_rsp.done) begin
            step    <= div_rsp.remainder[SLOT_W-1:0];
            wrapped <= 1'b0;
            state   <= ST_PROBE;
          end
        end

        ST_PROBE: begin
          if (pos_le0 && wrapped) begin
            // second wrap: give up, table untouched
            if (out_free) begin
              out_slot  <= '0;
              out_found <= 1'b0;
              out_ovf   <= 1'b1;
              state     <= ST_IDLE;
            end
          end else begin
            if (pos_le0) begin
              wrapped <= 1'b1;
            end
            pos   <= pos_probe;
            state <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          if (!entry_valid || entry_match) begin
            // empty slot takes the name; a match reports where it stands
            if (out_free) begin
              out_slot  <= SLOT_OUT_W'(pos[SLOT_W-1:0]);
              out_found <= entry_valid;
              out_ovf   <= 1'b0;
              state     <= ST_IDLE;
            end
          end else begin
            pos   <= pos - PW'(step);
            state <= ST_PROBE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {(OUT_DATA_W - SLOT_OUT_W - 2)'(0), out_ovf, out_found, out_slot};

`ifndef ASSERT_OFF
  // table is written only by the clearing sweep or an insert
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> (state == ST_CLEAR || state == ST_CHECK))
    else $error("table written outside sweep or insert");

  // divider finishes only while the sequencer waits on it
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV1_WAIT || state == ST_DIV2_WAIT))
    else $error("divider result arrived with nobody waiting");

  // a slot check always follows a probe read issued the cycle before
  a_check_after_probe: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && $past(state) != ST_CHECK) |-> $past(mem_rd_en))
    else $error("slot check without a table read");

  // found and overflow never come together in one result
  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(out_found && out_ovf))
    else $error("result flags found and overflow both set");

  // during a slot check the position stays inside the table
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> (!pos[PW-1] && pos <= SLOTS_M1))
    else $error("probe position outside the table");
`endif

endmodule

// ----- bench/tb_symbol_table_checker.sv -----
`timescale 1ns / 100ps
// checker for the symbol hash table core: keeps a shadow table, predicts each result
// depends on shtl_pkg; instantiated by tb_symbol_hash_table_lookup_insert_core
module tb_symbol_table_checker #(
  parameter int SLOTS = shtl_pkg::DEF_TABLE_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [shtl_pkg::NAME_W-1:0]     s_axis_tdata,  // symbol_name
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [shtl_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // slot_index, was_found,
                                                         // table_overflow, pad
  output int                              mismatches,
  output int                              outstanding
);
  import shtl_pkg::*;

  localparam int PAD_W = OUT_DATA_W - SLOT_OUT_W - 2;

  typedef struct packed {
    logic [PAD_W-1:0]      pad;
    logic                  table_overflow;
    logic                  was_found;
    logic [SLOT_OUT_W-1:0] slot_index;
  } lookup_result_t;

  logic [NAME_W-1:0] shadow_names [SLOTS];
  bit                shadow_used  [SLOTS];
  lookup_result_t    expected_lookups [$];

  // add byte, keep 16 bits, swap halves; stops at the first zero byte
  function automatic logic [HASH_W-1:0] name_hash(input logic [NAME_W-1:0] name);
    logic [HASH_W-1:0] h;
    logic [BYTE_W-1:0] b;
    bit                stop;
    h    = '0;
    stop = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      b = name[i*BYTE_W +: BYTE_W];
      if (b == '0) stop = 1'b1;
      if (!stop) begin
        h = h + HASH_W'(b);
        h = {h[BYTE_W-1:0], h[HASH_W-1:BYTE_W]};
      end
    end
    return h;
  endfunction

  // descending double-hash probe; a miss claims the empty slot
  function automatic lookup_result_t probe_and_insert(input logic [NAME_W-1:0] name);
    logic [HASH_W-1:0] h;
    int                p;
    int                stride;
    int                wraps;
    bit                done;
    lookup_result_t    r;
    h      = name_hash(name);
    stride = int'((h / SLOTS) % SLOTS);
    p      = int'(h % SLOTS);
    wraps  = 0;
    done   = 1'b0;
    r      = '0;
    while (!done) begin
      if (p <= 0) begin
        if (wraps != 0) begin
          r.table_overflow = 1'b1;
          done             = 1'b1;
        end else begin
          p     = p + SLOTS;
          wraps = wraps + 1;
        end
      end
      if (!done) begin
        p = p - 1;
        if (!shadow_used[p]) begin
          shadow_used[p]  = 1'b1;
          shadow_names[p] = name;
          r.slot_index    = p[SLOT_OUT_W-1:0];
          done            = 1'b1;
        end else if (shadow_names[p] == name) begin
          r.slot_index = p[SLOT_OUT_W-1:0];
          r.was_found  = 1'b1;
          done         = 1'b1;
        end else begin
          p = p - stride;
        end
      end
    end
    return r;
  endfunction

  task automatic report_field(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    if (rst) begin
      foreach (shadow_used[i]) shadow_used[i] = 1'b0;
      expected_lookups.delete();
      mismatches = 0;
    end else begin
      // result beats first: none can stem from a beat taken at this same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = lookup_result_t'(m_axis_tdata);
        if (expected_lookups.size() == 0) begin
          $display("%0t: result beat, expected none, actual tdata %h", $time, got);
          mismatches = mismatches + 1;
        end else begin
          want = expected_lookups.pop_front();
          if (got.slot_index != want.slot_index)
            report_field("slot_index", want.slot_index, got.slot_index);
          if (got.was_found != want.was_found)
            report_field("was_found", want.was_found, got.was_found);
          if (got.table_overflow != want.table_overflow)
            report_field("table_overflow", want.table_overflow, got.table_overflow);
          if (got.pad != want.pad)
            report_field("pad", want.pad, got.pad);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_lookups.push_back(probe_and_insert(s_axis_tdata));
    end
    outstanding = expected_lookups.size();
  end

endmodule

// ----- bench/tb_symbol_hash_table_lookup_insert_core.sv -----
`timescale 1ns / 100ps
// testbench top for symbol_hash_table_lookup_insert_core: clock, reset, stimulus, verdict
// depends on shtl_pkg, the core and tb_symbol_table_checker
module tb_symbol_hash_table_lookup_insert_core;
  import shtl_pkg::*;

  localparam int HALF_PERIOD    = 1;
  localparam int RESET_CYCLES   = 9;
  localparam int SLOTS          = DEF_TABLE_SLOTS;
  localparam int ITEMS_PER_PASS = 220;
  localparam int RANDOM_PASSES  = 5;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 200;
  // worst case is ~2k probes per item; the timeout leaves room for several times that
  localparam int TIMEOUT_NS     = 50_000_000;

  // a ladder of names occupying slots 0, 64, ... 960 so that a stride-64 probe
  // starting at slot 1 sees only foreign names and wraps twice
  localparam int LADDER_STRIDE  = 64;
  localparam int LADDER_RUNGS   = SLOTS / LADDER_STRIDE;

  typedef enum int {
    PH_STEADY,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH_IDLE
  } idle_phase_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [NAME_W-1:0]     s_axis_tdata  = '0;   // symbol_name
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // slot_index, was_found, table_overflow, pad
  int                    mismatches;
  int                    outstanding;

  int                    send_idle_pct  = 0;
  int                    recv_stall_pct = 0;
  bit                    hold_req       = 1'b0;
  bit                    hold_started   = 1'b0;
  int                    hold_left      = 0;

  // every name offered so far, the pool for repeat lookups
  logic [NAME_W-1:0]     offered_names [$];

  always #(HALF_PERIOD) clk = ~clk;

  symbol_hash_table_lookup_insert_core #(
    .TABLE_SLOTS (SLOTS)
  ) i_dut (
    .*
  );

  tb_symbol_table_checker #(
    .SLOTS (SLOTS)
  ) i_checker (
    .*
  );

  // receiver: random stalls, plus one long hold-off counted here so the core
  // backs up into its input while the sender keeps offering beats
  always @(negedge clk) begin
    if (hold_req && !hold_started) begin
      hold_started = 1'b1;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  // valid is only dropped for an idle gap, never lowered and raised in one step
  task automatic send_name(input logic [NAME_W-1:0] name);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= name;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    offered_names.push_back(name);
    @(negedge clk);
  endtask

  // two-byte name: hash is {b1, b0}, so start is {b1[1:0], b0} and stride is b1[7:2]+1
  function automatic logic [NAME_W-1:0] ladder_name(input int rung);
    logic [SLOT_OUT_W-1:0] start;
    start = SLOT_OUT_W'(rung * LADDER_STRIDE + 1);
    return {48'h0, 6'd1, start[9:8], start[7:0]};
  endfunction

  // printable name of 0..8 characters, zero padded
  function automatic logic [NAME_W-1:0] text_name(input int len);
    logic [NAME_W-1:0] n;
    n = '0;
    for (int i = 0; i < len; i++) n[i*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(126, 33));
    return n;
  endfunction

  // either raw bits or a name with junk after its terminating zero byte
  function automatic logic [NAME_W-1:0] noisy_name();
    logic [NAME_W-1:0] n;
    logic [NAME_W-1:0] above_cut;
    int                cut;
    if ($urandom_range(1) == 1) begin
      n = {$urandom, $urandom};
    end else begin
      cut       = $urandom_range(NAME_BYTES - 2, 0);
      above_cut = {NAME_W{1'b1}} << ((cut + 1) * BYTE_W);
      n         = text_name(cut) | ({$urandom, $urandom} & above_cut);
    end
    return n;
  endfunction

  initial begin
    logic [NAME_W-1:0] name;
    int                pick;
    idle_phase_t       phase;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // directed: no idling, empty table
    // fill the ladder, then the stride-64 probe overflows, twice (table untouched)
    for (int k = 0; k < LADDER_RUNGS; k++) send_name(ladder_name(k));
    send_name({48'h0, 6'(LADDER_STRIDE - 1), 2'b00, 8'h01});
    send_name({48'h0, 6'(LADDER_STRIDE - 1), 2'b00, 8'h01});
    send_name(ladder_name(5));                  // hit on a ladder name
    send_name('0);                              // empty name: hash zero, wraps at once
    send_name('0);                              // and found again at the top slot
    send_name({NAME_W{1'b1}});                  // all bytes 0xff
    send_name(64'h7a7a_7a7a_7a7a_7a7a);         // full eight characters
    send_name(64'h0000_0000_0000_0041);         // single character
    send_name(64'h5a5a_5a5a_5a5a_0041);         // same hash, junk after the zero byte
    send_name(64'h0000_0000_0000_0041);         // found despite the colliding neighbor

    // random: repeat lookups, fresh names, and noise, over the idling phases
    for (int pass = 0; pass < RANDOM_PASSES; pass++) begin
      phase = idle_phase_t'(pass % 4);
      case (phase)
        PH_STEADY: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        PH_SENDER_IDLE: begin
          send_idle_pct  = 63;
          recv_stall_pct = 0;
        end
        PH_RECEIVER_STALL: begin
          send_idle_pct  = 0;
          recv_stall_pct = 63;
        end
        PH_BOTH_IDLE: begin
          send_idle_pct  = 18;
          recv_stall_pct = 18;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      // long receiver hold-off at the start of the first pass
      if (pass == 0) hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PASS; n++) begin
        pick = $urandom_range(99);
        if (pick < 40)
          name = offered_names[$urandom_range(offered_names.size() - 1)];
        else if (pick < 85)
          name = text_name($urandom_range(NAME_BYTES, 1));
        else
          name = noisy_name();
        send_name(name);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    // a quiet stretch to catch any stray result beat
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
